// ===== hdl/present_block_cipher_defines.svh =====
// Assertion macros for the checker of the cipher block.
`ifndef PRESENT_BLOCK_CIPHER_DEFINES_SVH
`define PRESENT_BLOCK_CIPHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbc check failed");

// The consequent must hold in the cycle after the antecedent.
`define PBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbc check failed");

`endif

// ===== hdl/pbc_pkg.sv =====
`timescale 1ns / 1ps

package pbc_pkg;

    localparam int unsigned NUM_ROUND_KEYS = 32;
    localparam int unsigned NUM_ROUNDS     = NUM_ROUND_KEYS - 1;
    localparam int unsigned KEY_BITS       = 128;
    localparam int unsigned RC_BITS        = 5;
    localparam int unsigned INDEX_BITS     = 2;

    localparam logic [INDEX_BITS-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_KEY_MODE = 2'd2;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    localparam logic [3:0] SBOX [0:15] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    localparam logic [3:0] SBOX_INV [0:15] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    typedef struct packed {
        logic valid;
        logic action;
    } ctrl_t;

    typedef struct packed {
        logic                wide;
        logic [KEY_BITS-1:0] bits;
    } key_t;

    function automatic logic [63:0] sub_layer(input logic [63:0] s);
        logic [63:0] r;
        r = '0;
        for (int n = 0; n < 16; n++)
        begin
            r[n*4 +: 4] = SBOX[s[n*4 +: 4]];
        end
        return r;
    endfunction

    function automatic logic [63:0] sub_layer_inv(input logic [63:0] s);
        logic [63:0] r;
        r = '0;
        for (int n = 0; n < 16; n++)
        begin
            r[n*4 +: 4] = SBOX_INV[s[n*4 +: 4]];
        end
        return r;
    endfunction

    // Bit i moves to 16 * (i mod 4) + i / 4.
    function automatic logic [63:0] perm_layer(input logic [63:0] s);
        logic [63:0] r;
        logic [5:0]  idx;
        r = '0;
        for (int i = 0; i < 64; i++)
        begin
            idx = i[5:0];
            r[{idx[1:0], idx[5:2]}] = s[i];
        end
        return r;
    endfunction

    function automatic logic [63:0] perm_layer_inv(input logic [63:0] s);
        logic [63:0] r;
        logic [5:0]  idx;
        r = '0;
        for (int i = 0; i < 64; i++)
        begin
            idx = i[5:0];
            r[i] = s[{idx[1:0], idx[5:2]}];
        end
        return r;
    endfunction

    // An 80-bit key sits in bits 127..48 with the rest held at zero.
    function automatic logic [KEY_BITS-1:0] key_step(input logic [KEY_BITS-1:0] ks,
                                                     input logic wide,
                                                     input logic [RC_BITS-1:0] rc);
        logic [127:0] k128;
        logic [79:0]  k80;
        k128 = {ks[66:0], ks[127:67]};
        k128[127:124] = SBOX[k128[127:124]];
        k128[123:120] = SBOX[k128[123:120]];
        k128[66:62]   = k128[66:62] ^ rc;
        k80 = {ks[66:48], ks[127:67]};
        k80[79:76] = SBOX[k80[79:76]];
        k80[19:15] = k80[19:15] ^ rc;
        return wide ? k128 : {k80, 48'b0};
    endfunction

endpackage

// ===== hdl/pbc_key_cell.sv =====
`timescale 1ns / 1ps

module pbc_key_cell
(
    input  logic                         clk,
    input  pbc_pkg::key_t                key_prev,
    input  logic [pbc_pkg::RC_BITS-1:0]  round_num,
    output pbc_pkg::key_t                key_reg
);

    pbc_pkg::key_t key_next;

    always_comb
    begin
        key_next.wide = key_prev.wide;
        key_next.bits = pbc_pkg::key_step(key_prev.bits, key_prev.wide, round_num);
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== hdl/pbc_round_cell.sv =====
`timescale 1ns / 1ps

module pbc_round_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  pbc_pkg::ctrl_t ctrl_in,
    input  logic [63:0]    state_in,
    input  logic [63:0]    rk_enc,
    input  logic [63:0]    rk_dec,
    output pbc_pkg::ctrl_t ctrl_reg,
    output logic [63:0]    state_reg
);

    logic [63:0] mixed;
    logic [63:0] state_next;

    always_comb
    begin
        if (ctrl_in.action == pbc_pkg::ACT_DECRYPT)
        begin
            mixed      = state_in ^ rk_dec;
            state_next = pbc_pkg::sub_layer_inv(pbc_pkg::perm_layer_inv(mixed));
        end
        else
        begin
            mixed      = state_in ^ rk_enc;
            state_next = pbc_pkg::perm_layer(pbc_pkg::sub_layer(mixed));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/present_block_cipher.sv =====
`timescale 1ns / 1ps

// PRESENT 64-bit block cipher, ECB, 80- or 128-bit key.
// Configuration: write key_high (index 0), key_low (index 1) and key_mode
// (index 2) through cfg_write, cfg_index and cfg_data while no request is in
// flight. Every write restarts the key schedule, which ripples through a row
// of 31 key cells; the input channel is stalled after the write until it has settled.
// The same wait follows reset, which loads the all-zero 80-bit key.
// Input channel: in_valid, in_stall, action (0 encrypt, 1 decrypt) and
// block_in. Output channel: out_valid, out_stall and block_out.
// Each request passes a row of 31 round cells, one round per cell, and a final
// key addition into the output register. One request is taken in every cycle
// while in_stall is low.
// When the receiver stalls a valid result, the whole row of cells holds and
// in_stall is raised until the result is taken. Reset empties the row.

module present_block_cipher
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [pbc_pkg::INDEX_BITS-1:0]   cfg_index,
    input  logic [63:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [63:0]                      block_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [63:0]                      block_out
);

    localparam int unsigned NR = pbc_pkg::NUM_ROUNDS;
    localparam int unsigned CNT_BITS = $clog2(NR + 1);
    localparam logic [CNT_BITS-1:0] SETTLE_CYCLES = CNT_BITS'(NR);

    logic [63:0]         key_high_reg;
    logic [63:0]         key_low_reg;
    logic                key_mode_reg;
    logic [CNT_BITS-1:0] settle_reg;
    logic [CNT_BITS-1:0] settle_next;
    logic                out_valid_reg;
    logic [63:0]         block_out_reg;
    logic                advance;

    pbc_pkg::key_t  key_chain   [0:pbc_pkg::NUM_ROUND_KEYS-1];
    logic [63:0]    rk          [0:pbc_pkg::NUM_ROUND_KEYS-1];
    pbc_pkg::ctrl_t ctrl_chain  [0:NR-1];
    logic [63:0]    state_chain [0:NR-1];
    pbc_pkg::ctrl_t ctrl_first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            key_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pbc_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                pbc_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                pbc_pkg::REG_KEY_MODE: key_mode_reg <= cfg_data[0];
                default:               key_mode_reg <= key_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_write)
        begin
            settle_next = SETTLE_CYCLES;
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - CNT_BITS'(1);
        end
        else
        begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SETTLE_CYCLES;
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    always_comb
    begin
        key_chain[0].wide = key_mode_reg;
        key_chain[0].bits = key_mode_reg ? {key_high_reg, key_low_reg}
                                         : {key_high_reg, key_low_reg[63:48], 48'b0};
    end

    for (genvar k = 1; k < pbc_pkg::NUM_ROUND_KEYS; k++)
    begin : g_key
        pbc_key_cell u_key_cell
        (
            .clk       (clk),
            .key_prev  (key_chain[k-1]),
            .round_num (pbc_pkg::RC_BITS'(k)),
            .key_reg   (key_chain[k])
        );
    end

    for (genvar k = 0; k < pbc_pkg::NUM_ROUND_KEYS; k++)
    begin : g_rk
        assign rk[k] = key_chain[k].bits[pbc_pkg::KEY_BITS-1 -: 64];
    end

    assign advance    = !out_valid_reg || !out_stall;
    assign in_stall   = !advance || (settle_reg != '0);
    assign ctrl_first = '{valid: in_valid && !in_stall, action: action};

    for (genvar k = 0; k < NR; k++)
    begin : g_round
        if (k == 0)
        begin : g_head
            pbc_round_cell u_round_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .ctrl_in   (ctrl_first),
                .state_in  (block_in),
                .rk_enc    (rk[k]),
                .rk_dec    (rk[NR-k]),
                .ctrl_reg  (ctrl_chain[k]),
                .state_reg (state_chain[k])
            );
        end
        else
        begin : g_body
            pbc_round_cell u_round_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .ctrl_in   (ctrl_chain[k-1]),
                .state_in  (state_chain[k-1]),
                .rk_enc    (rk[k]),
                .rk_dec    (rk[NR-k]),
                .ctrl_reg  (ctrl_chain[k]),
                .state_reg (state_chain[k])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= ctrl_chain[NR-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            block_out_reg <= state_chain[NR-1]
                ^ ((ctrl_chain[NR-1].action == pbc_pkg::ACT_DECRYPT) ? rk[0] : rk[NR]);
        end
    end

    assign out_valid = out_valid_reg;
    assign block_out = block_out_reg;

endmodule

// ===== hdl/pbc_checker.sv =====
`timescale 1ns / 1ps
`include "present_block_cipher_defines.svh"

module pbc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_write,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] block_out
);

    // A new key must settle through the key cells before any request enters.
    `PBC_ASSERT_NEXT(a_cfg_stalls_input, cfg_write, in_stall)

    // A stalled result freezes the whole row, so the input must stall too.
    `PBC_ASSERT_SAME(a_out_stall_blocks_input, out_valid && out_stall, in_stall)

    `PBC_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(block_out))

endmodule

bind present_block_cipher pbc_checker u_pbc_checker (.*);

// ===== tb/sv/tb_present_block_cipher.sv =====
`timescale 1ns / 1ps

module tb_present_block_cipher;

    localparam logic [pbc_pkg::INDEX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam logic [63:0] FWD_BOX = 64'h21748FE3DA09B65C;
    localparam logic [63:0] INV_BOX = 64'hA970364BD21C8FE5;

    typedef struct packed {
        logic        act;
        logic [63:0] blk;
    } block_req_t;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [pbc_pkg::INDEX_BITS-1:0] cfg_index = '0;
    logic [63:0]                    cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           action = 1'b0;
    logic [63:0]                    block_in = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [63:0]                    block_out;

    block_req_t  block_req_q[$];
    logic [63:0] cipher_out_q[$];

    logic [63:0] key_hi_m;
    logic [63:0] key_lo_m;
    logic        key_wide_m;
    logic [63:0] round_key [0:pbc_pkg::NUM_ROUND_KEYS-1];

    logic        req_taken = 1'b0;
    int unsigned errors = 0;
    int unsigned results_seen = 0;

    block_req_t  next_req;
    int unsigned send_gap = 0;
    int unsigned send_calm_left = 0;
    bit          send_calm = 1'b0;

    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned recv_calm_left = 0;
    bit          recv_calm = 1'b0;

    logic [63:0] want;

    present_block_cipher u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .block_in  (block_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .block_out (block_out)
    );

    function automatic logic [3:0] box_lookup(input logic [63:0] box, input logic [3:0] x);
        return box[{x, 2'b00} +: 4];
    endfunction

    function automatic logic [63:0] nibble_sub(input logic [63:0] s, input logic [63:0] box);
        logic [63:0] r;
        for (int n = 0; n < 16; n++)
        begin
            r[n*4 +: 4] = box_lookup(box, s[n*4 +: 4]);
        end
        return r;
    endfunction

    function automatic logic [63:0] bit_spread(input logic [63:0] s);
        logic [63:0] r;
        r[63] = s[63];
        for (int i = 0; i < 63; i++)
        begin
            r[(16 * i) % 63] = s[i];
        end
        return r;
    endfunction

    function automatic logic [63:0] bit_gather(input logic [63:0] s);
        logic [63:0] r;
        r[63] = s[63];
        for (int i = 0; i < 63; i++)
        begin
            r[i] = s[(16 * i) % 63];
        end
        return r;
    endfunction

    function automatic void expand_round_keys();
        logic [127:0] k128;
        logic [79:0]  k80;
        k128 = {key_hi_m, key_lo_m};
        k80 = {key_hi_m, key_lo_m[63:48]};
        round_key[0] = key_hi_m;
        for (int r = 1; r < pbc_pkg::NUM_ROUND_KEYS; r++)
        begin
            if (key_wide_m)
            begin
                k128 = (k128 << 61) | (k128 >> 67);
                k128[127:124] = box_lookup(FWD_BOX, k128[127:124]);
                k128[123:120] = box_lookup(FWD_BOX, k128[123:120]);
                k128[66:62] = k128[66:62] ^ 5'(r);
                round_key[r] = k128[127:64];
            end
            else
            begin
                k80 = (k80 << 61) | (k80 >> 19);
                k80[79:76] = box_lookup(FWD_BOX, k80[79:76]);
                k80[19:15] = k80[19:15] ^ 5'(r);
                round_key[r] = k80[79:16];
            end
        end
    endfunction

    function automatic logic [63:0] present_cipher(input logic act, input logic [63:0] blk);
        logic [63:0] s;
        s = blk;
        if (act == pbc_pkg::ACT_ENCRYPT)
        begin
            for (int r = 0; r < pbc_pkg::NUM_ROUND_KEYS - 1; r++)
            begin
                s = bit_spread(nibble_sub(s ^ round_key[r], FWD_BOX));
            end
            s = s ^ round_key[pbc_pkg::NUM_ROUND_KEYS-1];
        end
        else
        begin
            s = s ^ round_key[pbc_pkg::NUM_ROUND_KEYS-1];
            for (int r = pbc_pkg::NUM_ROUND_KEYS - 2; r >= 0; r--)
            begin
                s = nibble_sub(bit_gather(s), INV_BOX) ^ round_key[r];
            end
        end
        return s;
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        if (calm)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_block(input logic act, input logic [63:0] blk);
        block_req_t req;
        req.act = act;
        req.blk = blk;
        block_req_q.push_back(req);
    endtask

    task automatic queue_random_blocks(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            queue_block(1'($urandom_range(0, 1)), pick_word());
        end
    endtask

    task automatic write_key_reg(input logic [pbc_pkg::INDEX_BITS-1:0] idx,
                                 input logic [63:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            pbc_pkg::REG_KEY_HIGH:
            begin
                key_hi_m = val;
                expand_round_keys();
            end
            pbc_pkg::REG_KEY_LOW:
            begin
                key_lo_m = val;
                expand_round_keys();
            end
            pbc_pkg::REG_KEY_MODE:
            begin
                key_wide_m = val[0];
                expand_round_keys();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_drained();
        while (block_req_q.size() != 0 || in_valid || cipher_out_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("** present_block_cipher: FAILED **");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (block_req_q.size() != 0)
            begin
                next_req = block_req_q.pop_front();
                in_valid <= 1'b1;
                action   <= next_req.act;
                block_in <= next_req.blk;
                if (send_calm_left == 0)
                begin
                    send_calm = ($urandom_range(0, 3) == 0);
                    send_calm_left = $urandom_range(20, 200);
                end
                else
                begin
                    send_calm_left--;
                end
                send_gap = pick_gap(send_calm);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The receiver holds off once for long enough that the pipeline fills and
    // the input side backs up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_calm_left == 0)
            begin
                recv_calm = ($urandom_range(0, 3) == 0);
                recv_calm_left = $urandom_range(50, 300);
            end
            else
            begin
                recv_calm_left--;
            end
            if (!hold_done && results_seen >= 40)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (cipher_out_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, block_out);
                end
                else
                begin
                    want = cipher_out_q.pop_front();
                    if (block_out !== want)
                    begin
                        errors++;
                        $display("%0t: block_out mismatch, expected %h, got %h",
                                 $time, want, block_out);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                cipher_out_q.push_back(present_cipher(action, block_in));
            end
        end
    end

    initial
    begin
        int unsigned random_items;
        int unsigned batch;
        key_hi_m = '0;
        key_lo_m = '0;
        key_wide_m = 1'b0;
        expand_round_keys();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_block(pbc_pkg::ACT_ENCRYPT, 64'h0);
        queue_block(pbc_pkg::ACT_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'h0);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_block(pbc_pkg::ACT_ENCRYPT, 64'h5555_5555_5555_5555);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
        wait_drained();

        // An 80-bit key of all ones; the write to the unused index must change nothing.
        write_key_reg(pbc_pkg::REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_key_reg(pbc_pkg::REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_key_reg(REG_UNUSED, {$urandom, $urandom});
        queue_block(pbc_pkg::ACT_ENCRYPT, 64'h0);
        queue_block(pbc_pkg::ACT_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'h0);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        // The mode register keeps only its lowest bit.
        write_key_reg(pbc_pkg::REG_KEY_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_block(pbc_pkg::ACT_ENCRYPT, 64'h0);
        queue_block(pbc_pkg::ACT_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'h0);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        write_key_reg(pbc_pkg::REG_KEY_HIGH, 64'h0);
        write_key_reg(pbc_pkg::REG_KEY_LOW, 64'h0);
        queue_block(pbc_pkg::ACT_ENCRYPT, 64'h0);
        queue_block(pbc_pkg::ACT_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'h0);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'h0123_4567_89AB_CDEF);
        wait_drained();

        write_key_reg(pbc_pkg::REG_KEY_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_block(pbc_pkg::ACT_ENCRYPT, 64'h0);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        // Only the top 16 bits of the low key word count for an 80-bit key.
        write_key_reg(pbc_pkg::REG_KEY_LOW, 64'h0000_FFFF_FFFF_FFFF);
        queue_block(pbc_pkg::ACT_ENCRYPT, 64'h0);
        queue_block(pbc_pkg::ACT_DECRYPT, 64'h0);
        wait_drained();

        random_items = 0;
        while (random_items < 1600)
        begin
            if ($urandom_range(0, 1))
            begin
                write_key_reg(pbc_pkg::REG_KEY_HIGH, pick_word());
            end
            if ($urandom_range(0, 1))
            begin
                write_key_reg(pbc_pkg::REG_KEY_LOW, pick_word());
            end
            if ($urandom_range(0, 1))
            begin
                write_key_reg(pbc_pkg::REG_KEY_MODE, {$urandom, $urandom});
            end
            if ($urandom_range(0, 5) == 0)
            begin
                write_key_reg(REG_UNUSED, {$urandom, $urandom});
            end
            batch = (random_items == 0) ? 300 : $urandom_range(60, 140);
            queue_random_blocks(batch);
            random_items += batch;
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (errors == 0)
        begin
            $display("** present_block_cipher: PASSED **");
        end
        else
        begin
            $display("** present_block_cipher: FAILED **");
        end
        $finish;
    end

endmodule
